/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL files of the motion estimator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AME_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AME_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AME_ASSERT(lbl, prop, msg)
`define AME_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hdl/ame_pkg.sv */
`default_nettype none
package ame_pkg;

    localparam int SETTLE_COUNT_DEF = 64;

    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [47:0] MS_MAX  = 48'hFFFF_FFFF_FFFF;

    localparam logic [16:0] GRAVITY_RATE_RST    = 17'd206;
    localparam logic [16:0] ACTIVITY_RATE_RST   = 17'd328;
    localparam logic [16:0] LEAK_RATE_RST       = 17'd131;
    localparam logic [19:0] STILL_THRESHOLD_RST = 20'd1311;
    localparam logic [23:0] SAMPLE_PERIOD_RST   = 24'd16777;
    localparam logic [63:0] AXIS_CAL_RST        = 64'd2305843387170816;

    typedef enum logic [2:0] {
        REG_GRAVITY_RATE,
        REG_ACTIVITY_RATE,
        REG_LEAK_RATE,
        REG_STILL_THRESHOLD,
        REG_SAMPLE_PERIOD,
        REG_AXIS_X_CAL,
        REG_AXIS_Y_CAL,
        REG_AXIS_Z_CAL
    } cfg_idx_t;

    typedef struct packed {
        logic [16:0]      gravity_rate;
        logic [16:0]      activity_rate;
        logic [16:0]      leak_rate;
        logic [19:0]      still_threshold;
        logic [23:0]      sample_period;
        logic [2:0][63:0] axis_cal;
    } cfg_t;

    // Datapath micro-operations. Multiplying operations load the product
    // register; their result is folded into the state in the next cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_DIRECT,
        OP_RAWG,
        OP_BIASG,
        OP_GOLD,
        OP_GNEW,
        OP_DIFF,
        OP_DSQ,
        OP_MSLO,
        OP_MSHI,
        OP_MGLO,
        OP_MGHI,
        OP_SQ1,
        OP_VINT,
        OP_VLEAK,
        OP_VSQ,
        OP_SQ2
    } mop_t;

    typedef struct packed {
        mop_t       op;
        logic [1:0] axis;
    } uop_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        uop_t uop;
        logic capture;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic sq_done;
    } dp_status_t;

endpackage
`default_nettype wire

/* hdl/ame_sqrt.sv */
`default_nettype none
`include "assert_macros.svh"
module ame_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             busy,
    output logic             done,
    output logic [31:0]      root
);

    logic [63:0] val_reg, val_next;
    logic [34:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [34:0] rem_sh;
    logic [34:0] trial;

    // One result bit per cycle, restoring bit-pair method.
    always_comb
    begin
        rem_sh    = {rem_reg[32:0], val_reg[63:62]};
        trial     = {1'b0, root_reg, 2'b01};
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            val_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[61:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

    `AME_ASSERT_ALWAYS(a_no_restart, start |-> !busy_reg, "square root restarted while busy")
    `AME_ASSERT(a_done_after_busy, done_reg |-> $past(busy_reg) && !busy_reg, "stray done")

endmodule
`default_nettype wire

/* hdl/ame_datapath.sv */
`default_nettype none
module ame_datapath #(
    parameter int SETTLE_COUNT = ame_pkg::SETTLE_COUNT_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ame_pkg::cfg_t       cfg,
    input  wire ame_pkg::dp_cmd_t    cmd,
    output ame_pkg::dp_status_t      status,
    input  wire logic [47:0]         in_data,
    output logic [31:0]              speed_level,
    output logic [31:0]              activity_level,
    output logic                     settled
);

    localparam logic [31:0] SETTLE_W = 32'(SETTLE_COUNT);

    function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
        logic signed [71:0] maxv;
        logic signed [71:0] minv;
        maxv = 72'sd2147483647;
        minv = -72'sd2147483648;
        if (x > maxv)
            return 32'sh7FFF_FFFF;
        else if (x < minv)
            return 32'sh8000_0000;
        else
            return x[31:0];
    endfunction

    function automatic logic [16:0] clip_rate(input logic [16:0] r);
        return (r[16] && (r[15:0] != 16'd0)) ? ame_pkg::ONE_Q16 : r;
    endfunction

    // Architectural state.
    logic signed [31:0] g_reg [3];
    logic signed [31:0] g_next [3];
    logic signed [31:0] v_reg [3];
    logic signed [31:0] v_next [3];
    logic [47:0]        ms_reg, ms_next;
    logic [31:0]        count_reg, count_next;

    // Working registers.
    logic signed [15:0] raw_reg [3];
    logic signed [15:0] raw_next [3];
    logic signed [31:0] a_reg [3];
    logic signed [31:0] a_next [3];
    logic signed [31:0] d_reg [3];
    logic signed [31:0] d_next [3];
    logic signed [71:0] acc_reg, acc_next;
    logic [47:0]        mag2_reg, mag2_next;
    logic signed [65:0] prod_reg;
    ame_pkg::mop_t      op_d_reg;
    logic [1:0]         axis_d_reg;
    logic               sq_sel_reg, sq_sel_next;
    logic [31:0]        act_reg, act_next;
    logic               still_reg, still_next;
    logic [31:0]        speed_reg, speed_next;
    logic [31:0]        out_speed_reg, out_speed_next;
    logic [31:0]        out_act_reg, out_act_next;
    logic               out_settled_reg, out_settled_next;

    logic signed [32:0] mul_a, mul_b;
    logic [16:0]        rg, ra, keep;
    logic               sq_start;
    logic [63:0]        sq_src;
    logic               sq_busy, sq_done;
    logic [31:0]        sq_root;
    logic [1:0]         ax;

    assign rg   = clip_rate(cfg.gravity_rate);
    assign ra   = clip_rate(cfg.activity_rate);
    assign keep = ame_pkg::ONE_Q16 - clip_rate(cfg.leak_rate);
    assign ax   = cmd.uop.axis;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.uop.op)
            ame_pkg::OP_RAWG:
            begin
                mul_a = 33'(raw_reg[ax]);
                mul_b = 33'(signed'(cfg.axis_cal[ax][63:32]));
            end
            ame_pkg::OP_BIASG:
            begin
                mul_a = 33'(signed'(cfg.axis_cal[ax][31:0]));
                mul_b = 33'(signed'(cfg.axis_cal[ax][63:32]));
            end
            ame_pkg::OP_GOLD:
            begin
                mul_a = 33'(g_reg[ax]);
                mul_b = {16'd0, ame_pkg::ONE_Q16 - rg};
            end
            ame_pkg::OP_GNEW:
            begin
                mul_a = 33'(a_reg[ax]);
                mul_b = {16'd0, rg};
            end
            ame_pkg::OP_DSQ:
            begin
                mul_a = 33'(d_reg[ax]);
                mul_b = 33'(d_reg[ax]);
            end
            ame_pkg::OP_MSLO:
            begin
                mul_a = {1'b0, ms_reg[31:0]};
                mul_b = {16'd0, ame_pkg::ONE_Q16 - ra};
            end
            ame_pkg::OP_MSHI:
            begin
                mul_a = {17'd0, ms_reg[47:32]};
                mul_b = {16'd0, ame_pkg::ONE_Q16 - ra};
            end
            ame_pkg::OP_MGLO:
            begin
                mul_a = {1'b0, mag2_reg[31:0]};
                mul_b = {16'd0, ra};
            end
            ame_pkg::OP_MGHI:
            begin
                mul_a = {17'd0, mag2_reg[47:32]};
                mul_b = {16'd0, ra};
            end
            ame_pkg::OP_VINT:
            begin
                mul_a = 33'(d_reg[ax]);
                mul_b = {9'd0, cfg.sample_period};
            end
            ame_pkg::OP_VLEAK:
            begin
                mul_a = 33'(v_reg[ax]);
                mul_b = {16'd0, keep};
            end
            ame_pkg::OP_VSQ:
            begin
                mul_a = 33'(v_reg[ax]);
                mul_b = 33'(v_reg[ax]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Fold the registered product of the previous operation into the state.
    always_comb
    begin
        logic signed [71:0] prod_x;
        logic signed [71:0] t;
        prod_x = 72'(prod_reg);
        t      = '0;
        for (int k = 0; k < 3; k++)
        begin
            g_next[k]   = g_reg[k];
            v_next[k]   = v_reg[k];
            a_next[k]   = a_reg[k];
            d_next[k]   = d_reg[k];
            raw_next[k] = raw_reg[k];
        end
        ms_next          = ms_reg;
        count_next       = count_reg;
        acc_next         = acc_reg;
        mag2_next        = mag2_reg;
        sq_sel_next      = sq_sel_reg;
        act_next         = act_reg;
        still_next       = still_reg;
        speed_next       = speed_reg;
        out_speed_next   = out_speed_reg;
        out_act_next     = out_act_reg;
        out_settled_next = out_settled_reg;
        sq_start         = 1'b0;
        sq_src           = '0;

        case (op_d_reg)
            ame_pkg::OP_DIRECT:
            begin
                for (int k = 0; k < 3; k++)
                    d_next[k] = {{12{raw_reg[k][15]}}, raw_reg[k], 4'b0000};
            end
            ame_pkg::OP_RAWG:
                acc_next = prod_x <<< 8;
            ame_pkg::OP_BIASG:
            begin
                t = acc_reg - prod_x + 72'sd8388608;
                a_next[axis_d_reg] = sat32(t >>> 24);
            end
            ame_pkg::OP_GOLD:
                acc_next = prod_x;
            ame_pkg::OP_GNEW:
            begin
                t = acc_reg + prod_x + 72'sd32768;
                // A raw first sample seeds the gravity average.
                g_next[axis_d_reg] = (count_reg == 32'd0) ? a_reg[axis_d_reg]
                                                          : sat32(t >>> 16);
            end
            ame_pkg::OP_DIFF:
                d_next[axis_d_reg] = sat32(72'(a_reg[axis_d_reg]) - 72'(g_reg[axis_d_reg]));
            ame_pkg::OP_DSQ, ame_pkg::OP_VSQ:
                acc_next = (axis_d_reg == 2'd0) ? prod_x : acc_reg + prod_x;
            ame_pkg::OP_MSLO:
            begin
                mag2_next = (acc_reg[71:48] != 24'd0) ? ame_pkg::MS_MAX : acc_reg[47:0];
                acc_next  = prod_x;
            end
            ame_pkg::OP_MSHI:
                acc_next = acc_reg + (prod_x <<< 32);
            ame_pkg::OP_MGLO:
                acc_next = acc_reg + prod_x;
            ame_pkg::OP_MGHI:
            begin
                t = acc_reg + (prod_x <<< 32) + 72'sd32768;
                ms_next = (t[71:64] != 8'd0) ? ame_pkg::MS_MAX : t[63:16];
            end
            ame_pkg::OP_SQ1:
            begin
                sq_start    = 1'b1;
                sq_src      = {16'd0, ms_reg};
                sq_sel_next = 1'b0;
            end
            ame_pkg::OP_VINT:
            begin
                t = prod_x + 72'sd8388608;
                v_next[axis_d_reg] = sat32(72'(v_reg[axis_d_reg]) + (t >>> 24));
            end
            ame_pkg::OP_VLEAK:
            begin
                // At rest the leaked velocity is halved again.
                if (still_reg)
                begin
                    t = prod_x + 72'sd65536;
                    v_next[axis_d_reg] = sat32(t >>> 17);
                end
                else
                begin
                    t = prod_x + 72'sd32768;
                    v_next[axis_d_reg] = sat32(t >>> 16);
                end
            end
            ame_pkg::OP_SQ2:
            begin
                sq_start    = 1'b1;
                sq_src      = acc_reg[63:0];
                sq_sel_next = 1'b1;
            end
            default:
                t = '0;
        endcase

        if (sq_done)
        begin
            if (!sq_sel_reg)
            begin
                act_next   = sq_root;
                still_next = sq_root < {12'd0, cfg.still_threshold};
            end
            else
                speed_next = sq_root;
        end

        if (cmd.capture)
        begin
            raw_next[0] = in_data[15:0];
            raw_next[1] = in_data[31:16];
            raw_next[2] = in_data[47:32];
        end

        if (cmd.load_out)
        begin
            if (count_reg != 32'hFFFF_FFFF)
                count_next = count_reg + 32'd1;
            out_speed_next   = speed_reg;
            out_act_next     = act_reg;
            out_settled_next = count_next >= SETTLE_W;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                g_reg[k] <= '0;
                v_reg[k] <= '0;
            end
            ms_reg     <= '0;
            count_reg  <= '0;
            op_d_reg   <= ame_pkg::OP_NONE;
            axis_d_reg <= '0;
            sq_sel_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                g_reg[k] <= g_next[k];
                v_reg[k] <= v_next[k];
            end
            ms_reg     <= ms_next;
            count_reg  <= count_next;
            op_d_reg   <= cmd.uop.op;
            axis_d_reg <= cmd.uop.axis;
            sq_sel_reg <= sq_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            raw_reg[k] <= raw_next[k];
            a_reg[k]   <= a_next[k];
            d_reg[k]   <= d_next[k];
        end
        prod_reg        <= mul_a * mul_b;
        acc_reg         <= acc_next;
        mag2_reg        <= mag2_next;
        act_reg         <= act_next;
        still_reg       <= still_next;
        speed_reg       <= speed_next;
        out_speed_reg   <= out_speed_next;
        out_act_reg     <= out_act_next;
        out_settled_reg <= out_settled_next;
    end

    ame_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_src),
        .busy     (sq_busy),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_comb
    begin
        status         = '0;
        status.sq_done = sq_done && !sq_busy;
    end

    assign speed_level    = out_speed_reg;
    assign activity_level = out_act_reg;
    assign settled        = out_settled_reg;

endmodule
`default_nettype wire

/* hdl/ame_ctrl.sv */
`default_nettype none
module ame_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_valid,
    input  wire logic                s_action,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ame_pkg::dp_cmd_t         cmd,
    input  wire ame_pkg::dp_status_t status
);

    localparam int PROG_LEN = 35;
    localparam int PC_W     = $clog2(PROG_LEN);

    localparam logic [PC_W-1:0] PC_DIRECT = PC_W'(0);
    localparam logic [PC_W-1:0] PC_SKIP   = PC_W'(1);
    localparam logic [PC_W-1:0] PC_RAW    = PC_W'(2);
    localparam logic [PC_W-1:0] PC_COMMON = PC_W'(17);
    localparam logic [PC_W-1:0] PC_SQ1    = PC_W'(24);
    localparam logic [PC_W-1:0] PC_SQ2    = PC_W'(34);

    // Operation sequence. Gaps are placed so that no operation reads a
    // value that the operation just before it is still writing back.
    function automatic ame_pkg::uop_t uprog(input logic [PC_W-1:0] pc);
        ame_pkg::uop_t u;
        u.axis = 2'd0;
        case (pc)
            6'd0:    u.op = ame_pkg::OP_DIRECT;
            6'd2:    u.op = ame_pkg::OP_RAWG;
            6'd3:    u.op = ame_pkg::OP_BIASG;
            6'd4:    u.op = ame_pkg::OP_GOLD;
            6'd5:    u.op = ame_pkg::OP_GNEW;
            6'd6:    u.op = ame_pkg::OP_DIFF;
            6'd7:    begin u.op = ame_pkg::OP_RAWG;  u.axis = 2'd1; end
            6'd8:    begin u.op = ame_pkg::OP_BIASG; u.axis = 2'd1; end
            6'd9:    begin u.op = ame_pkg::OP_GOLD;  u.axis = 2'd1; end
            6'd10:   begin u.op = ame_pkg::OP_GNEW;  u.axis = 2'd1; end
            6'd11:   begin u.op = ame_pkg::OP_DIFF;  u.axis = 2'd1; end
            6'd12:   begin u.op = ame_pkg::OP_RAWG;  u.axis = 2'd2; end
            6'd13:   begin u.op = ame_pkg::OP_BIASG; u.axis = 2'd2; end
            6'd14:   begin u.op = ame_pkg::OP_GOLD;  u.axis = 2'd2; end
            6'd15:   begin u.op = ame_pkg::OP_GNEW;  u.axis = 2'd2; end
            6'd16:   begin u.op = ame_pkg::OP_DIFF;  u.axis = 2'd2; end
            6'd17:   u.op = ame_pkg::OP_DSQ;
            6'd18:   begin u.op = ame_pkg::OP_DSQ;   u.axis = 2'd1; end
            6'd19:   begin u.op = ame_pkg::OP_DSQ;   u.axis = 2'd2; end
            6'd20:   u.op = ame_pkg::OP_MSLO;
            6'd21:   u.op = ame_pkg::OP_MSHI;
            6'd22:   u.op = ame_pkg::OP_MGLO;
            6'd23:   u.op = ame_pkg::OP_MGHI;
            6'd24:   u.op = ame_pkg::OP_SQ1;
            6'd25:   u.op = ame_pkg::OP_VINT;
            6'd26:   begin u.op = ame_pkg::OP_VINT;  u.axis = 2'd1; end
            6'd27:   begin u.op = ame_pkg::OP_VINT;  u.axis = 2'd2; end
            6'd28:   u.op = ame_pkg::OP_VLEAK;
            6'd29:   begin u.op = ame_pkg::OP_VLEAK; u.axis = 2'd1; end
            6'd30:   begin u.op = ame_pkg::OP_VLEAK; u.axis = 2'd2; end
            6'd31:   u.op = ame_pkg::OP_VSQ;
            6'd32:   begin u.op = ame_pkg::OP_VSQ;   u.axis = 2'd1; end
            6'd33:   begin u.op = ame_pkg::OP_VSQ;   u.axis = 2'd2; end
            6'd34:   u.op = ame_pkg::OP_SQ2;
            default: u.op = ame_pkg::OP_NONE;
        endcase
        return u;
    endfunction

    ame_pkg::state_t state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            out_valid_reg, out_valid_next;
    logic            slot_free;

    assign slot_free = !out_valid_reg || m_ready;

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg;
        if (m_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ame_pkg::ST_IDLE:
            begin
                if (s_valid)
                begin
                    state_next = ame_pkg::ST_RUN;
                    pc_next    = s_action ? PC_DIRECT : PC_RAW;
                end
            end
            ame_pkg::ST_RUN:
            begin
                if (pc_reg == PC_SQ1 || pc_reg == PC_SQ2)
                    state_next = ame_pkg::ST_WAIT;
                else if (pc_reg == PC_SKIP)
                    pc_next = PC_COMMON;
                else
                    pc_next = pc_reg + PC_W'(1);
            end
            ame_pkg::ST_WAIT:
            begin
                if (status.sq_done)
                begin
                    pc_next    = pc_reg + PC_W'(1);
                    state_next = (pc_reg == PC_SQ2) ? ame_pkg::ST_FINISH : ame_pkg::ST_RUN;
                end
            end
            ame_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next     = ame_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
                state_next = ame_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.uop.op   = ame_pkg::OP_NONE;
        cmd.capture  = (state_reg == ame_pkg::ST_IDLE) && s_valid;
        cmd.load_out = (state_reg == ame_pkg::ST_FINISH) && slot_free;
        if (state_reg == ame_pkg::ST_RUN)
            cmd.uop = uprog(pc_reg);
        s_ready = (state_reg == ame_pkg::ST_IDLE);
        m_valid = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ame_pkg::ST_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/accel_motion_estimator.sv */
`default_nettype none
`include "assert_macros.svh"
// Three-axis motion estimator. Each input transfer carries one sample: with
// tuser low it holds raw accelerometer counts, which are calibrated per axis
// and have a slowly tracked gravity average removed (a raw first sample
// seeds that average); with tuser high it holds gravity-free acceleration in
// g scaled by 4096. Every sample yields exactly one output transfer with the
// speed magnitude, the RMS activity and a settled flag. Samples are handled
// one at a time: the next sample can be taken in the cycle after the result
// is loaded. The time per sample is set by the two square roots, each a
// 32-step pass of a bit-serial unit, and by the roughly thirty products that
// share one 33 by 33 bit multiplier. A result waits in the output register
// while the next sample is already accepted. Register writes take effect at
// once and belong in idle periods only.
module accel_motion_estimator #(
    parameter int SETTLE_COUNT = ame_pkg::SETTLE_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    // Sample stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    input  wire logic        s_axis_tuser,  // action
    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata   // speed_level[31:0], activity_level[63:32],
                                            // settled[64], zero fill above
);

    ame_pkg::cfg_t       cfg_reg;
    ame_pkg::dp_cmd_t    cmd;
    ame_pkg::dp_status_t status;
    logic [31:0]         speed_level;
    logic [31:0]         activity_level;
    logic                settled;

    // Configuration registers; each of the eight indices selects a register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gravity_rate    <= ame_pkg::GRAVITY_RATE_RST;
            cfg_reg.activity_rate   <= ame_pkg::ACTIVITY_RATE_RST;
            cfg_reg.leak_rate       <= ame_pkg::LEAK_RATE_RST;
            cfg_reg.still_threshold <= ame_pkg::STILL_THRESHOLD_RST;
            cfg_reg.sample_period   <= ame_pkg::SAMPLE_PERIOD_RST;
            cfg_reg.axis_cal        <= {3{ame_pkg::AXIS_CAL_RST}};
        end
        else if (cfg_we)
        begin
            case (ame_pkg::cfg_idx_t'(cfg_index))
                ame_pkg::REG_GRAVITY_RATE:    cfg_reg.gravity_rate    <= cfg_data[16:0];
                ame_pkg::REG_ACTIVITY_RATE:   cfg_reg.activity_rate   <= cfg_data[16:0];
                ame_pkg::REG_LEAK_RATE:       cfg_reg.leak_rate       <= cfg_data[16:0];
                ame_pkg::REG_STILL_THRESHOLD: cfg_reg.still_threshold <= cfg_data[19:0];
                ame_pkg::REG_SAMPLE_PERIOD:   cfg_reg.sample_period   <= cfg_data[23:0];
                ame_pkg::REG_AXIS_X_CAL:      cfg_reg.axis_cal[0]     <= cfg_data;
                ame_pkg::REG_AXIS_Y_CAL:      cfg_reg.axis_cal[1]     <= cfg_data;
                ame_pkg::REG_AXIS_Z_CAL:      cfg_reg.axis_cal[2]     <= cfg_data;
                default:                      cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // The controller steps through the operation sequence and owns both
    // handshakes; the datapath holds all arithmetic and the estimator state.
    ame_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_axis_tvalid),
        .s_action (s_axis_tuser),
        .s_ready  (s_axis_tready),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .cmd      (cmd),
        .status   (status)
    );

    ame_datapath #(
        .SETTLE_COUNT (SETTLE_COUNT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .status         (status),
        .in_data        (s_axis_tdata),
        .speed_level    (speed_level),
        .activity_level (activity_level),
        .settled        (settled)
    );

    assign m_axis_tdata = {7'd0, settled, activity_level, speed_level};

    // A new result only goes into the output register once it is free.
    `AME_ASSERT(a_load_free, cmd.load_out |-> (!m_axis_tvalid || m_axis_tready), "result overwritten")
    // After a sample transfer the block works on it and takes no other.
    `AME_ASSERT(a_one_at_a_time, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "second sample taken")

endmodule
`default_nettype wire

/* sim/testbench.sv */
`default_nettype none
// Self-checking bench for the three-axis motion estimator. A scoreboard class
// keeps its own copy of the estimator state and configuration. Every accepted
// sample is run through this copy and the predicted result is queued. Every
// result transfer from the block is compared against the oldest queued
// prediction.
class motion_scoreboard;
    logic [16:0] gravity_rate, activity_rate, leak_rate;
    logic [19:0] still_threshold;
    logic [23:0] sample_period;
    logic [63:0] axis_cal [3];
    longint gravity_est [3];
    longint velocity [3];
    logic [63:0] mean_square;
    logic [31:0] sample_count;
    logic [64:0] pending [$];
    int errors;

    function new();
        int k;
        gravity_rate = ame_pkg::GRAVITY_RATE_RST;
        activity_rate = ame_pkg::ACTIVITY_RATE_RST;
        leak_rate = ame_pkg::LEAK_RATE_RST;
        still_threshold = ame_pkg::STILL_THRESHOLD_RST;
        sample_period = ame_pkg::SAMPLE_PERIOD_RST;
        for (k = 0; k < 3; k++)
        begin
            axis_cal[k] = ame_pkg::AXIS_CAL_RST;
            gravity_est[k] = 0;
            velocity[k] = 0;
        end
        mean_square = 0;
        sample_count = 0;
        errors = 0;
    endfunction

    // The >>> on a longint is an arithmetic shift, so this rounds halves up.
    static function longint round_shift(longint x, int n);
        return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    static function longint sat32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    static function longint clip_rate(logic [16:0] r);
        return (r > ame_pkg::ONE_Q16) ? 65536 : longint'(r);
    endfunction

    static function logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function void write_reg(ame_pkg::cfg_idx_t idx, logic [63:0] value);
        case (idx)
            ame_pkg::REG_GRAVITY_RATE:    gravity_rate = value[16:0];
            ame_pkg::REG_ACTIVITY_RATE:   activity_rate = value[16:0];
            ame_pkg::REG_LEAK_RATE:       leak_rate = value[16:0];
            ame_pkg::REG_STILL_THRESHOLD: still_threshold = value[19:0];
            ame_pkg::REG_SAMPLE_PERIOD:   sample_period = value[23:0];
            ame_pkg::REG_AXIS_X_CAL:      axis_cal[0] = value;
            ame_pkg::REG_AXIS_Y_CAL:      axis_cal[1] = value;
            default:                      axis_cal[2] = value;
        endcase
    endfunction

    // Advances the predicted state by one sample and queues the result.
    function void note_sample(logic gravity_free, logic [47:0] samples);
        longint dyn [3];
        longint accel [3];
        longint rg, ra, keep, raw, gain, bias, v;
        logic [63:0] mag2, vsq, activity, speed;
        int shift, k;
        if (gravity_free)
        begin
            for (k = 0; k < 3; k++)
                dyn[k] = longint'($signed(samples[16*k +: 16])) * 16;
        end
        else
        begin
            rg = clip_rate(gravity_rate);
            for (k = 0; k < 3; k++)
            begin
                raw = longint'($signed(samples[16*k +: 16]));
                gain = longint'($signed(axis_cal[k][63:32]));
                bias = longint'($signed(axis_cal[k][31:0]));
                accel[k] = sat32(round_shift((raw * 256 - bias) * gain, 24));
                gravity_est[k] = sat32(round_shift(
                    gravity_est[k] * (65536 - rg) + accel[k] * rg, 16));
            end
            if (sample_count == 0)
            begin
                for (k = 0; k < 3; k++)
                    gravity_est[k] = accel[k];
            end
            for (k = 0; k < 3; k++)
                dyn[k] = sat32(accel[k] - gravity_est[k]);
        end
        mag2 = 0;
        for (k = 0; k < 3; k++)
            mag2 += dyn[k] * dyn[k];
        if (mag2 > ame_pkg::MS_MAX)
            mag2 = ame_pkg::MS_MAX;
        ra = clip_rate(activity_rate);
        mean_square = (mean_square * (65536 - ra) + mag2 * ra + 32768) >> 16;
        if (mean_square > ame_pkg::MS_MAX)
            mean_square = ame_pkg::MS_MAX;
        activity = floor_sqrt(mean_square);
        keep = 65536 - clip_rate(leak_rate);
        shift = (activity < still_threshold) ? 17 : 16;
        vsq = 0;
        for (k = 0; k < 3; k++)
        begin
            v = sat32(velocity[k] + round_shift(dyn[k] * longint'(sample_period), 24));
            v = sat32(round_shift(v * keep, shift));
            velocity[k] = v;
            vsq += v * v;
        end
        speed = floor_sqrt(vsq);
        if (sample_count != 32'hFFFF_FFFF)
            sample_count++;
        pending.push_back({sample_count >= 64, activity[31:0], speed[31:0]});
    endfunction

    function void check_result(logic [71:0] data);
        logic [64:0] exp_res;
        if (pending.size() == 0)
        begin
            $display("%0t: result %h arrived with nothing expected", $time, data);
            errors++;
            return;
        end
        exp_res = pending.pop_front();
        if (data[31:0] !== exp_res[31:0])
        begin
            $display("%0t: speed_level expected %0d actual %0d", $time,
                     exp_res[31:0], data[31:0]);
            errors++;
        end
        if (data[63:32] !== exp_res[63:32])
        begin
            $display("%0t: activity_level expected %0d actual %0d", $time,
                     exp_res[63:32], data[63:32]);
            errors++;
        end
        if (data[64] !== exp_res[64])
        begin
            $display("%0t: settled expected %0d actual %0d", $time, exp_res[64], data[64]);
            errors++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Extra wait after the results, well beyond the slowest sample's time.
    localparam int DRAIN_CYCLES = 300;
    localparam longint CYCLE_LIMIT = 3_000_000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [63:0] cfg_data;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [71:0] m_axis_tdata;

    // Idle percentages for the sender and the receiver, changed per phase.
    int send_idle_pct;
    int recv_idle_pct;
    // When set, the receiver process holds tready low for a long stretch.
    bit hold_off_request;
    longint cycle_count;
    motion_scoreboard board;

    accel_motion_estimator dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Cycle counter that ends a hung run.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request so
    // the output register and then the input side fill up and stall.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            // Outputs are sampled at the edge, before the new tready lands.
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
            if (hold_off_request)
            begin
                hold_off_request = 0;
                m_axis_tready <= 1'b0;
                for (stall = 0; stall < 600; stall++)
                begin
                    @(posedge clk);
                end
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Holds the write for one edge, then waits with the enable low so the
    // next write never lands in the same time step as the release.
    task automatic write_register(ame_pkg::cfg_idx_t idx, logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.write_reg(idx, value);
        @(posedge clk);
    endtask

    // Offers one sample and returns once its transfer has taken place.
    // tvalid stays high afterwards so a following sample can go straight on.
    task automatic send_sample(logic gravity_free, logic [47:0] samples);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= gravity_free;
        s_axis_tdata <= samples;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_sample(gravity_free, samples);
    endtask

    // Waits for every predicted result, then lets the datapath settle so
    // that a register write cannot land on a sample still in flight.
    task automatic drain;
        int k;
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        for (k = 0; k < DRAIN_CYCLES; k++)
            @(posedge clk);
    endtask

    function automatic logic [47:0] random_samples(int mode);
        logic [47:0] s;
        int k;
        s = {$urandom, $urandom};
        // Most samples near a gravity-like level; some at full range.
        if (mode != 0)
        begin
            for (k = 0; k < 3; k++)
                s[16*k +: 16] = 16'(int'($urandom_range(400)) - 200 + (k == 2 ? 4096 : 0));
        end
        return s;
    endfunction

    // Gain and bias with small values most of the time, extremes sometimes.
    function automatic logic [63:0] random_cal();
        case ($urandom_range(3))
            0: return {$urandom, $urandom};
            1: return {32'd536871 + 32'($urandom_range(200000)),
                       32'($signed(int'($urandom_range(4000)) - 2000))};
            2: return {32'(-int'($urandom_range(600000))), 32'($urandom_range(255))};
            default: return ame_pkg::AXIS_CAL_RST;
        endcase
    endfunction

    task automatic random_config;
        write_register(ame_pkg::REG_GRAVITY_RATE, 64'($urandom_range(131071)));
        write_register(ame_pkg::REG_ACTIVITY_RATE, 64'($urandom_range(70000)));
        write_register(ame_pkg::REG_LEAK_RATE, 64'($urandom_range(2000)));
        write_register(ame_pkg::REG_STILL_THRESHOLD, 64'($urandom_range(1048575)));
        write_register(ame_pkg::REG_SAMPLE_PERIOD, 64'($urandom_range(16777215)));
        write_register(ame_pkg::REG_AXIS_X_CAL, random_cal());
        write_register(ame_pkg::REG_AXIS_Y_CAL, random_cal());
        write_register(ame_pkg::REG_AXIS_Z_CAL, random_cal());
    endtask

    task automatic random_block(int count);
        int n;
        for (n = 0; n < count; n++)
            send_sample(($urandom_range(3) == 0), random_samples($urandom_range(3)));
    endtask

    initial
    begin
        int phase;
        board = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = ame_pkg::REG_GRAVITY_RATE;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_request = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (5) @(posedge clk);

        // Directed part. A gravity-free first sample means no seeding later.
        send_sample(1'b1, {16'sh7FFF, 16'sh8000, 16'h0001});
        send_sample(1'b0, {16'sh8000, 16'sh7FFF, 16'h0000});
        send_sample(1'b0, {16'h1000, 16'h0000, 16'hFFFF});
        send_sample(1'b1, {16'sh8000, 16'sh8000, 16'sh8000});
        send_sample(1'b1, {16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        drain();
        // Two rates above one, no leak, top threshold, zero sample period.
        write_register(ame_pkg::REG_GRAVITY_RATE, 64'h1FFFF);
        write_register(ame_pkg::REG_ACTIVITY_RATE, 64'h1FFFF);
        write_register(ame_pkg::REG_LEAK_RATE, 64'd0);
        write_register(ame_pkg::REG_STILL_THRESHOLD, 64'hFFFFF);
        write_register(ame_pkg::REG_SAMPLE_PERIOD, 64'd0);
        write_register(ame_pkg::REG_AXIS_X_CAL, 64'h7FFF_FFFF_8000_0000);
        write_register(ame_pkg::REG_AXIS_Y_CAL, 64'h8000_0000_7FFF_FFFF);
        write_register(ame_pkg::REG_AXIS_Z_CAL, 64'hFFFF_FFFF_FFFF_FFFF);
        send_sample(1'b0, {16'sh7FFF, 16'sh8000, 16'sh7FFF});
        send_sample(1'b0, {16'sh8000, 16'sh7FFF, 16'sh8000});
        send_sample(1'b1, {16'sh7FFF, 16'sh8000, 16'sh7FFF});
        drain();
        // Full leak, zero rates and the longest sample period.
        write_register(ame_pkg::REG_GRAVITY_RATE, 64'd0);
        write_register(ame_pkg::REG_ACTIVITY_RATE, 64'd0);
        write_register(ame_pkg::REG_LEAK_RATE, 64'd65536);
        write_register(ame_pkg::REG_STILL_THRESHOLD, 64'd0);
        write_register(ame_pkg::REG_SAMPLE_PERIOD, 64'hFFFFFF);
        write_register(ame_pkg::REG_AXIS_X_CAL, ame_pkg::AXIS_CAL_RST);
        write_register(ame_pkg::REG_AXIS_Y_CAL, ame_pkg::AXIS_CAL_RST);
        write_register(ame_pkg::REG_AXIS_Z_CAL, ame_pkg::AXIS_CAL_RST);
        send_sample(1'b0, {16'h1000, 16'h0100, 16'h0010});
        send_sample(1'b1, {16'h0FFF, 16'hF000, 16'h0001});
        drain();
        write_register(ame_pkg::REG_LEAK_RATE, 64'd1);
        write_register(ame_pkg::REG_SAMPLE_PERIOD, 64'd1);
        send_sample(1'b0, {16'h2000, 16'h0000, 16'hE000});
        drain();

        // Random part in three idling phases, each split by config changes.
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 58 : 0;
            recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 25 : 0;
            random_config();
            if (phase == 2)
                hold_off_request = 1;
            random_block(250);
            drain();
            random_config();
            random_block(250);
            drain();
        end

        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
